// File: src/gww_pkg.sv
package gww_pkg;

	localparam int MAX_WIDTH = 32;
	localparam int LEN_W     = $clog2(MAX_WIDTH + 1);
	localparam int ADDR_W    = $clog2(MAX_WIDTH);
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic [7:0] CH_SPACE   = 8'd32;
	localparam logic [7:0] CH_NEWLINE = 8'd10;

	localparam logic [5:0] LINE_WIDTH_RST = 6'd31;
	localparam logic [7:0] LINE_LIMIT_RST = 8'd80;

	localparam logic REG_LINE_WIDTH = 1'b0;
	localparam logic REG_LINE_LIMIT = 1'b1;

	typedef struct packed {
		logic [7:0] char_code;
		logic       is_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       has_char;
		logic       line_end;
		logic [7:0] line_number;
		logic       text_end;
		logic       run_last;
	} out_item_t;

	typedef struct packed {
		logic       push;
		out_item_t  item;
	} out_push_t;

	typedef struct packed {
		logic [5:0] line_width;
		logic [7:0] line_limit;
	} cfg_t;

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_EMIT_RD = 6'b000010,
		S_EMIT_WR = 6'b000100,
		S_MARK    = 6'b001000,
		S_MOVE_RD = 6'b010000,
		S_MOVE_WR = 6'b100000
	} state_t;

endpackage

// File: src/gww_cfg.sv
module gww_cfg
	import gww_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [5:0] line_width_q;
	logic [7:0] line_limit_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RST;
			line_limit_q <= LINE_LIMIT_RST;
		end else if (wr_en) begin
			case (paddr[2])
				REG_LINE_WIDTH: line_width_q <= pwdata[5:0];
				REG_LINE_LIMIT: line_limit_q <= pwdata[7:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_LINE_WIDTH: prdata = PDATA_W'(line_width_q);
			REG_LINE_LIMIT: prdata = PDATA_W'(line_limit_q);
			default:        prdata = '0;
		endcase
	end

	assign cfg.line_width = line_width_q;
	assign cfg.line_limit = line_limit_q;

endmodule

// File: src/gww_seq.sv
module gww_seq
	import gww_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	input  logic      slot_free,
	output out_push_t push
);

	state_t            state_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  lsp_q;
	logic              skip_q;
	logic [7:0]        lines_q;
	logic [LEN_W-1:0]  aw_q;
	logic [LEN_W-1:0]  idx_q;
	logic [LEN_W-1:0]  k_q;
	logic [LEN_W-1:0]  emit_len_q;
	logic [7:0]        ln_q;
	logic              at_end_q;
	logic              mv_q;
	logic              mark_le_q;
	logic [7:0]        c_q;
	logic [7:0]        line_buf_q [MAX_WIDTH];
	logic [7:0]        rd_data_q;

	logic              acc;
	logic [LEN_W-1:0]  wn;
	logic [LEN_W-1:0]  aw_eff;
	logic              can_emit;
	logic              is_sp;
	logic              is_nl;
	logic              ignore;
	logic              full;
	logic [LEN_W-1:0]  lsp_new;
	logic [LEN_W-1:0]  cut_pre;
	logic [LEN_W-1:0]  cut;
	logic [LEN_W-1:0]  idx_inc;
	logic              le;
	logic              mv_last;
	logic [7:0]        mv_char;
	logic              keep;
	logic [LEN_W-1:0]  k_inc;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [7:0]        mem_wdata;

	assign in_ready = (state_q == S_IDLE);
	assign acc      = in_valid && in_ready;

	always_comb begin
		if (cfg.line_width == '0)
			wn = LEN_W'(1);
		else if (int'(cfg.line_width) > MAX_WIDTH)
			wn = LEN_W'(MAX_WIDTH);
		else
			wn = LEN_W'(cfg.line_width);
	end

	assign aw_eff   = (len_q == '0) ? wn : aw_q;
	assign can_emit = lines_q < cfg.line_limit;
	assign is_sp    = in_data.char_code == CH_SPACE;
	assign is_nl    = in_data.char_code == CH_NEWLINE;
	assign ignore   = skip_q && is_sp;
	assign full     = len_q >= aw_eff;
	assign lsp_new  = is_sp ? len_q : lsp_q;
	assign cut_pre  = (lsp_new != '0) ? lsp_new : aw_eff;
	assign cut      = (cut_pre > len_q) ? len_q : cut_pre;

	assign idx_inc = idx_q + LEN_W'(1);
	assign le      = idx_inc == emit_len_q;
	assign mv_last = idx_q == len_q;
	assign mv_char = mv_last ? c_q : rd_data_q;
	assign keep    = !((k_q == '0) && (mv_char == CH_SPACE));
	assign k_inc   = k_q + LEN_W'(1);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = len_q[ADDR_W-1:0];
		mem_wdata = in_data.char_code;
		if (state_q == S_IDLE) begin
			mem_we = acc && !in_data.is_end && !ignore && !is_nl && !full;
		end else if (state_q == S_MOVE_WR) begin
			mem_we    = keep;
			mem_waddr = k_q[ADDR_W-1:0];
			mem_wdata = mv_char;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			line_buf_q[mem_waddr] <= mem_wdata;
		rd_data_q <= line_buf_q[idx_q[ADDR_W-1:0]];
	end

	always_comb begin
		push.push = 1'b0;
		push.item = '0;
		case (state_q)
			S_EMIT_WR: begin
				push.push             = slot_free;
				push.item.out_char    = rd_data_q;
				push.item.has_char    = 1'b1;
				push.item.line_end    = le;
				push.item.line_number = ln_q;
				push.item.text_end    = le && at_end_q;
				push.item.run_last    = le;
			end
			S_MARK: begin
				push.push             = slot_free;
				push.item.line_end    = mark_le_q;
				push.item.line_number = ln_q;
				push.item.text_end    = at_end_q;
				push.item.run_last    = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			len_q      <= '0;
			lsp_q      <= '0;
			skip_q     <= 1'b0;
			lines_q    <= '0;
			aw_q       <= LEN_W'(LINE_WIDTH_RST);
			idx_q      <= '0;
			k_q        <= '0;
			emit_len_q <= '0;
			ln_q       <= '0;
			at_end_q   <= 1'b0;
			mv_q       <= 1'b0;
			mark_le_q  <= 1'b0;
			c_q        <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc && in_data.is_end) begin
						ln_q       <= can_emit ? lines_q : '0;
						mark_le_q  <= can_emit;
						at_end_q   <= 1'b1;
						mv_q       <= 1'b0;
						emit_len_q <= len_q;
						idx_q      <= '0;
						lines_q    <= '0;
						len_q      <= '0;
						lsp_q      <= '0;
						skip_q     <= 1'b0;
						aw_q       <= wn;
						state_q    <= (can_emit && len_q != '0) ? S_EMIT_RD : S_MARK;
					end else if (acc) begin
						aw_q <= aw_eff;
						if (!ignore) begin
							skip_q <= 1'b0;
							if (is_nl) begin
								at_end_q   <= 1'b0;
								mv_q       <= 1'b0;
								mark_le_q  <= 1'b1;
								ln_q       <= lines_q;
								emit_len_q <= len_q;
								idx_q      <= '0;
								len_q      <= '0;
								lsp_q      <= '0;
								if (can_emit) begin
									lines_q <= lines_q + 8'd1;
									state_q <= (len_q == '0) ? S_MARK : S_EMIT_RD;
								end
							end else if (full) begin
								c_q        <= in_data.char_code;
								at_end_q   <= 1'b0;
								mv_q       <= 1'b1;
								ln_q       <= lines_q;
								emit_len_q <= cut;
								lsp_q      <= '0;
								k_q        <= '0;
								if (can_emit) begin
									lines_q <= lines_q + 8'd1;
									idx_q   <= '0;
									state_q <= S_EMIT_RD;
								end else begin
									idx_q   <= cut;
									state_q <= S_MOVE_RD;
								end
							end else begin
								len_q <= len_q + LEN_W'(1);
								lsp_q <= lsp_new;
							end
						end
					end
				end
				S_EMIT_RD: state_q <= S_EMIT_WR;
				S_EMIT_WR: begin
					if (slot_free) begin
						idx_q <= idx_inc;
						if (!le)
							state_q <= S_EMIT_RD;
						else if (mv_q)
							state_q <= S_MOVE_RD;
						else
							state_q <= S_IDLE;
					end
				end
				S_MARK: begin
					if (slot_free)
						state_q <= S_IDLE;
				end
				S_MOVE_RD: state_q <= S_MOVE_WR;
				S_MOVE_WR: begin
					if (keep) begin
						k_q <= k_inc;
						if (mv_char == CH_SPACE)
							lsp_q <= k_q;
					end
					if (mv_last) begin
						len_q   <= keep ? k_inc : k_q;
						skip_q  <= !keep && (k_q == '0);
						state_q <= S_IDLE;
					end else begin
						idx_q   <= idx_inc;
						state_q <= S_MOVE_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: src/gww_obuf.sv
module gww_obuf
	import gww_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  out_push_t push,
	output logic      slot_free,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic      valid_q;
	out_item_t item_q;

	assign slot_free = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= push.push;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && push.push)
			item_q <= push.item;
	end

endmodule

// File: src/greedy_word_wrap_core.sv
// Channel   Handshake               Payload
// input     in_valid / in_ready     in_data  (in_item_t: char_code, is_end)
// output    out_valid / out_ready   out_data (out_item_t: one character or marker)
// config    psel/penable/pwrite     paddr, pwdata, prdata; pready tied high
//
// A byte that is appended to the open line is written to the line buffer when it is accepted.
// Closing a line reads each character from the buffer, then pushes it; an empty line or marker
// is pushed alone. A cut then reads and rewrites each leftover byte and the new byte.
// in_ready is high only while the sequencer is idle; out_ready low stalls the output register
// and holds the sequencer.
// arst_n clears control state; the line buffer holds no reset value.
module greedy_word_wrap_core
	import gww_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  in_item_t           in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output out_item_t          out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t      cfg;
	out_push_t push;
	logic      slot_free;

	gww_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gww_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.slot_free (slot_free),
		.push      (push)
	);

	gww_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.slot_free (slot_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

`ifndef SYNTHESIS
	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.is_end |=> !in_ready)
		else $error("end of text transfer did not start a line close");

	a_text_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.text_end |-> out_data.run_last)
		else $error("text_end on a result that is not the last of its step");

	a_line_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.line_end |-> out_data.run_last)
		else $error("line_end on a result that is not the last of its step");
`endif

endmodule
